/* rtl/hpad_pkg.sv */
`timescale 1ns / 1ps

package hpad_pkg;

    localparam int DIMENSIONS = 3;
    localparam int FRAC_BITS  = 16;

    localparam int WORD_W     = 32;
    localparam int ACC_W      = 64;
    localparam int MUL_W      = WORD_W + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int KP_W       = ACC_W + WORD_W;
    localparam int NUM_COEF   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int ROOT_STEPS = ACC_W / 2;
    localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CONST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_SUM_SQ = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CROSS  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_RADIAL = CFG_IDX_W'(3);

    // coefficient slots
    localparam logic [1:0] K_CONST  = 2'd0;
    localparam logic [1:0] K_SUM_SQ = 2'd1;
    localparam logic [1:0] K_CROSS  = 2'd2;
    localparam logic [1:0] K_RADIAL = 2'd3;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic                    busy;
        logic [WORD_W-1:0]       root;
    } t_sqrt_stat;

    typedef struct packed {
        logic                    clip;
        logic signed [ACC_W-1:0] val;
    } t_sat;

    function automatic t_sat sat_add(input logic signed [ACC_W-1:0] a,
                                     input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        t_sat r;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        r.clip = s[ACC_W] ^ s[ACC_W-1];
        r.val  = r.clip ? (s[ACC_W] ? ACC_MIN : ACC_MAX) : s[ACC_W-1:0];
        return r;
    endfunction

    function automatic t_sat sat_sub(input logic signed [ACC_W-1:0] a,
                                     input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        t_sat r;
        s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
        r.clip = s[ACC_W] ^ s[ACC_W-1];
        r.val  = r.clip ? (s[ACC_W] ? ACC_MIN : ACC_MAX) : s[ACC_W-1:0];
        return r;
    endfunction

    // floor(kp / 2^F), clipped to the accumulator range
    function automatic t_sat sat_term(input logic signed [KP_W-1:0] kp);
        logic signed [KP_W-1:0] t;
        logic [KP_W-ACC_W:0] hi;
        t_sat r;
        t  = kp >>> FRAC_BITS;
        hi = t[KP_W-1:ACC_W-1];
        r.clip = !((&hi) || (~|hi));
        r.val  = r.clip ? (t[KP_W-1] ? ACC_MIN : ACC_MAX) : t[ACC_W-1:0];
        return r;
    endfunction

endpackage

/* rtl/hpad_mul.sv */
`timescale 1ns / 1ps

// shared signed multiplier, product registered
module hpad_mul (
    input  logic                                  i_clk,
    input  logic signed [hpad_pkg::MUL_W-1:0]     i_a,
    input  logic signed [hpad_pkg::MUL_W-1:0]     i_b,
    output logic signed [hpad_pkg::PROD_W-1:0]    o_prod
);

    always_ff @(posedge i_clk) begin
        o_prod <= i_a * i_b;
    end

endmodule

/* rtl/hpad_isqrt.sv */
`timescale 1ns / 1ps

// bit-serial integer square root, one result bit per cycle
module hpad_isqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [hpad_pkg::ACC_W-1:0]        i_radicand,
    output hpad_pkg::t_sqrt_stat              o_stat
);

    logic                                 r_busy;
    logic [hpad_pkg::ROOT_CNT_W-1:0]      r_cnt;
    logic [hpad_pkg::ACC_W-1:0]           r_rem;
    logic [hpad_pkg::ACC_W-1:0]           r_res;
    logic [hpad_pkg::ACC_W-1:0]           w_bit;
    logic [hpad_pkg::ACC_W-1:0]           w_trial;
    logic                                 w_ge;

    always_comb begin
        w_bit   = hpad_pkg::ACC_W'(1) << {~r_cnt, 1'b0};
        w_trial = r_res + w_bit;
        w_ge    = r_rem >= w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_rem  <= i_radicand;
                r_res  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - w_trial;
                    r_res <= (r_res >> 1) + w_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_cnt <= r_cnt + 1'b1;
                if (&r_cnt) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.root = r_res[hpad_pkg::WORD_W-1:0];

endmodule

/* rtl/harmonic_pair_action_difference.sv */
`timescale 1ns / 1ps

// A new input beat is taken only once the previous slice is done (o_in_stall);
//   the 32-step square root, run once for the trial path and once for the old
//   path, is the longest part of this work.
// Reset (i_rst_n low, synchronous): coefficients, previous slices, radii,
//   sum and clip flag go to zero; the block is idle with no result pending.
module harmonic_pair_action_difference (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [hpad_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [hpad_pkg::WORD_W-1:0]           i_cfg_data,
    // slice input
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [hpad_pkg::WORD_W-1:0]    i_trial_dx,
    input  logic signed [hpad_pkg::WORD_W-1:0]    i_trial_dy,
    input  logic signed [hpad_pkg::WORD_W-1:0]    i_trial_dz,
    input  logic signed [hpad_pkg::WORD_W-1:0]    i_old_dx,
    input  logic signed [hpad_pkg::WORD_W-1:0]    i_old_dy,
    input  logic signed [hpad_pkg::WORD_W-1:0]    i_old_dz,
    input  logic                                  i_first_slice,
    input  logic                                  i_last_slice,
    // result output
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [hpad_pkg::ACC_W-1:0]     o_action_difference,
    output logic                                  o_saturated
);

    // Sequencer: per path (trial, then old) a fixed program of steps drives
    // the shared multiplier. Each product is registered, then folded into its
    // target the cycle after; a coefficient product (two 33x33 partials) is
    // floored, clipped and added to the constant or, for the cross and radial
    // terms, taken from the action. The root of |a|^2 runs alongside.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_SUM_T,
        ST_SUM_O,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SQA,
        OP_SQB,
        OP_DOT,
        OP_KLO,
        OP_KHI,
        OP_DIFF
    } t_op;

    localparam logic [4:0] STEP_SQRT = 5'd4;
    localparam logic [4:0] STEP_WAIT = 5'd13;
    localparam logic [4:0] STEP_END  = 5'd19;

    t_state                                 r_state;
    logic [4:0]                             r_step;
    logic                                   r_path;     // 0 trial, 1 old
    logic                                   r_first;
    logic                                   r_last;

    logic [hpad_pkg::WORD_W-1:0]            r_coef [hpad_pkg::NUM_COEF];
    logic signed [hpad_pkg::WORD_W-1:0]     r_cur_t  [3];
    logic signed [hpad_pkg::WORD_W-1:0]     r_cur_o  [3];
    logic signed [hpad_pkg::WORD_W-1:0]     r_prev_t [3];
    logic signed [hpad_pkg::WORD_W-1:0]     r_prev_o [3];
    logic [hpad_pkg::WORD_W-1:0]            r_prev_tr;
    logic [hpad_pkg::WORD_W-1:0]            r_prev_or;

    logic [hpad_pkg::ACC_W-1:0]             r_na;
    logic [hpad_pkg::ACC_W-1:0]             r_nb;
    logic signed [hpad_pkg::ACC_W-1:0]      r_dot;
    logic [hpad_pkg::ACC_W-1:0]             r_q;
    logic signed [hpad_pkg::KP_W-1:0]       r_kp;
    logic signed [hpad_pkg::ACC_W-1:0]      r_act;
    logic signed [hpad_pkg::ACC_W-1:0]      r_act_t;
    logic                                   r_iclip;
    logic signed [hpad_pkg::ACC_W-1:0]      r_sum;
    logic                                   r_clip;

    t_op                                    r_pend_op;
    logic [1:0]                             r_pend_k;
    logic                                   r_fin_v;
    logic [1:0]                             r_fin_k;

    logic                                   r_out_valid;
    logic signed [hpad_pkg::ACC_W-1:0]      r_out_ad;
    logic                                   r_out_sat;

    t_op                                    n_op;
    logic [1:0]                             n_idx;
    logic [1:0]                             n_kidx;
    logic signed [hpad_pkg::WORD_W-1:0]     w_ca;
    logic signed [hpad_pkg::WORD_W-1:0]     w_cb;
    logic [hpad_pkg::WORD_W-1:0]            w_rb;
    logic [hpad_pkg::WORD_W-1:0]            w_diff;
    logic [hpad_pkg::ACC_W-1:0]             w_s;
    logic [hpad_pkg::ACC_W-1:0]             w_x;
    logic [hpad_pkg::WORD_W-1:0]            w_k;
    logic signed [hpad_pkg::MUL_W-1:0]      w_ma;
    logic signed [hpad_pkg::MUL_W-1:0]      w_mb;
    logic signed [hpad_pkg::PROD_W-1:0]     w_prod;
    logic signed [hpad_pkg::KP_W-1:0]       w_prod_ext;
    hpad_pkg::t_sat                         w_term;
    hpad_pkg::t_sat                         w_act_nx;
    hpad_pkg::t_sat                         w_sum_t;
    hpad_pkg::t_sat                         w_sum_o;
    hpad_pkg::t_sqrt_stat                   w_sq;
    logic                                   w_sq_start;
    logic                                   w_in_acc;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;

    // program of the current path
    always_comb begin
        n_op   = OP_NONE;
        n_idx  = 2'd0;
        n_kidx = hpad_pkg::K_SUM_SQ;
        if (r_state == ST_RUN) begin
            unique case (r_step)
                5'd0, 5'd1, 5'd2: begin
                    n_op  = OP_SQA;
                    n_idx = r_step[1:0];
                end
                5'd3, 5'd4, 5'd5: begin
                    n_op  = OP_SQB;
                    n_idx = 2'(r_step - 5'd3);
                end
                5'd6, 5'd7, 5'd8: begin
                    n_op  = OP_DOT;
                    n_idx = 2'(r_step - 5'd6);
                end
                5'd9:  n_op = OP_KLO;
                5'd10: n_op = OP_KHI;
                5'd11: begin
                    n_op   = OP_KLO;
                    n_kidx = hpad_pkg::K_CROSS;
                end
                5'd12: begin
                    n_op   = OP_KHI;
                    n_kidx = hpad_pkg::K_CROSS;
                end
                5'd13: n_op = w_sq.busy ? OP_NONE : OP_DIFF;
                5'd15: begin
                    n_op   = OP_KLO;
                    n_kidx = hpad_pkg::K_RADIAL;
                end
                5'd16: begin
                    n_op   = OP_KHI;
                    n_kidx = hpad_pkg::K_RADIAL;
                end
                default: n_op = OP_NONE;
            endcase
        end
    end

    // operand selection
    always_comb begin
        w_ca = r_path ? r_cur_o[n_idx] : r_cur_t[n_idx];
        w_cb = r_path ? r_prev_o[n_idx] : r_prev_t[n_idx];
        if (32'(n_idx) >= hpad_pkg::DIMENSIONS) begin
            w_ca = '0;
            w_cb = '0;
        end
        w_rb   = r_path ? r_prev_or : r_prev_tr;
        w_diff = (w_sq.root >= w_rb) ? (w_sq.root - w_rb) : (w_rb - w_sq.root);
        w_s    = (r_na >> hpad_pkg::FRAC_BITS) + (r_nb >> hpad_pkg::FRAC_BITS);
        w_k    = r_coef[n_kidx];
        unique case (n_kidx)
            hpad_pkg::K_CROSS:  w_x = r_dot;
            hpad_pkg::K_RADIAL: w_x = r_q;
            default:            w_x = w_s;
        endcase
        unique case (n_op)
            OP_SQA: begin
                w_ma = {w_ca[hpad_pkg::WORD_W-1], w_ca};
                w_mb = {w_ca[hpad_pkg::WORD_W-1], w_ca};
            end
            OP_SQB: begin
                w_ma = {w_cb[hpad_pkg::WORD_W-1], w_cb};
                w_mb = {w_cb[hpad_pkg::WORD_W-1], w_cb};
            end
            OP_DOT: begin
                w_ma = {w_ca[hpad_pkg::WORD_W-1], w_ca};
                w_mb = {w_cb[hpad_pkg::WORD_W-1], w_cb};
            end
            OP_KLO: begin
                w_ma = {w_k[hpad_pkg::WORD_W-1], w_k};
                w_mb = {1'b0, w_x[hpad_pkg::WORD_W-1:0]};
            end
            OP_KHI: begin
                w_ma = {w_k[hpad_pkg::WORD_W-1], w_k};
                w_mb = {w_x[hpad_pkg::ACC_W-1], w_x[hpad_pkg::ACC_W-1:hpad_pkg::WORD_W]};
            end
            OP_DIFF: begin
                w_ma = {1'b0, w_diff};
                w_mb = {1'b0, w_diff};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_sq_start = (r_state == ST_RUN) && (r_step == STEP_SQRT);

    hpad_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    hpad_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sq_start),
        .i_radicand (r_na),
        .o_stat     (w_sq)
    );

    // finishing stage: floor/clip the coefficient product, fold into action
    always_comb begin
        w_prod_ext = {{(hpad_pkg::KP_W - hpad_pkg::PROD_W){w_prod[hpad_pkg::PROD_W-1]}},
                      w_prod};
        w_term = hpad_pkg::sat_term(r_kp);
        if (r_fin_k == hpad_pkg::K_SUM_SQ) begin
            w_act_nx = hpad_pkg::sat_add(
                {{(hpad_pkg::ACC_W - hpad_pkg::WORD_W){r_coef[hpad_pkg::K_CONST][
                    hpad_pkg::WORD_W-1]}}, r_coef[hpad_pkg::K_CONST]},
                w_term.val);
        end else begin
            w_act_nx = hpad_pkg::sat_sub(r_act, w_term.val);
        end
        w_sum_t = hpad_pkg::sat_add(r_sum, r_act_t);
        w_sum_o = hpad_pkg::sat_sub(r_sum, r_act);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_path      <= 1'b0;
            r_pend_op   <= OP_NONE;
            r_fin_v     <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_clip      <= 1'b0;
            r_prev_tr   <= '0;
            r_prev_or   <= '0;
            for (int i = 0; i < hpad_pkg::NUM_COEF; i++) begin
                r_coef[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_prev_t[i] <= '0;
                r_prev_o[i] <= '0;
            end
        end else begin
            // configuration; out-of-range indexes are dropped
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    hpad_pkg::CFG_COEF_CONST:  r_coef[hpad_pkg::K_CONST]  <= i_cfg_data;
                    hpad_pkg::CFG_COEF_SUM_SQ: r_coef[hpad_pkg::K_SUM_SQ] <= i_cfg_data;
                    hpad_pkg::CFG_COEF_CROSS:  r_coef[hpad_pkg::K_CROSS]  <= i_cfg_data;
                    hpad_pkg::CFG_COEF_RADIAL: r_coef[hpad_pkg::K_RADIAL] <= i_cfg_data;
                    default: ;
                endcase
            end

            // product fold-in, behind the multiplier's product register
            r_pend_op <= n_op;
            r_pend_k  <= n_kidx;
            r_fin_v   <= 1'b0;
            unique case (r_pend_op)
                OP_SQA:  r_na  <= r_na + w_prod[hpad_pkg::ACC_W-1:0];
                OP_SQB:  r_nb  <= r_nb + w_prod[hpad_pkg::ACC_W-1:0];
                OP_DOT:  r_dot <= r_dot + hpad_pkg::ACC_W'(w_prod >>> hpad_pkg::FRAC_BITS);
                OP_DIFF: r_q   <= w_prod[hpad_pkg::ACC_W-1:0] >> hpad_pkg::FRAC_BITS;
                OP_KLO:  r_kp  <= w_prod_ext;
                OP_KHI: begin
                    r_kp    <= r_kp + (w_prod_ext <<< hpad_pkg::WORD_W);
                    r_fin_v <= 1'b1;
                    r_fin_k <= r_pend_k;
                end
                default: ;
            endcase
            if (r_fin_v) begin
                r_act   <= w_act_nx.val;
                r_iclip <= r_iclip | w_term.clip | w_act_nx.clip;
            end

            // a result loaded below replaces the beat taken this cycle
            if (r_out_valid && !i_out_stall && !(r_state == ST_DONE && r_last)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_cur_t[0] <= i_trial_dx;
                        r_cur_t[1] <= i_trial_dy;
                        r_cur_t[2] <= i_trial_dz;
                        r_cur_o[0] <= i_old_dx;
                        r_cur_o[1] <= i_old_dy;
                        r_cur_o[2] <= i_old_dz;
                        r_first    <= i_first_slice;
                        r_last     <= i_last_slice;
                        r_na       <= '0;
                        r_nb       <= '0;
                        r_dot      <= '0;
                        r_iclip    <= 1'b0;
                        r_step     <= '0;
                        r_path     <= 1'b0;
                        r_state    <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (r_step == STEP_END) begin
                        r_step <= '0;
                        r_na   <= '0;
                        r_nb   <= '0;
                        r_dot  <= '0;
                        if (!r_path) begin
                            r_act_t   <= r_act;
                            r_prev_tr <= w_sq.root;
                            for (int i = 0; i < 3; i++) begin
                                r_prev_t[i] <= r_cur_t[i];
                            end
                            r_path <= 1'b1;
                        end else begin
                            r_prev_or <= w_sq.root;
                            for (int i = 0; i < 3; i++) begin
                                r_prev_o[i] <= r_cur_o[i];
                            end
                            r_state <= ST_SUM_T;
                        end
                    end else if (!(r_step == STEP_WAIT && w_sq.busy)) begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_SUM_T: begin
                    if (r_first) begin
                        r_sum  <= '0;
                        r_clip <= 1'b0;
                    end else begin
                        r_sum  <= w_sum_t.val;
                        r_clip <= r_clip | r_iclip | w_sum_t.clip;
                    end
                    r_state <= ST_SUM_O;
                end
                ST_SUM_O: begin
                    if (!r_first) begin
                        r_sum  <= w_sum_o.val;
                        r_clip <= r_clip | w_sum_o.clip;
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_last) begin
                        r_state <= ST_IDLE;
                    end else if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_ad    <= r_sum;
                        r_out_sat   <= r_clip;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_action_difference = r_out_ad;
    assign o_saturated         = r_out_sat;

    // root unit must have finished both paths before a new beat
    a_sqrt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_sq.busy)
        else $error("root unit busy while idle");

    // nothing left in the product pipe once idle
    a_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_pend_op == OP_NONE && !r_fin_v))
        else $error("multiplier work pending while idle");

    // an accepted beat starts the trial path at step zero
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_RUN && r_step == '0 && !r_path))
        else $error("bad program start");

    // a result beat only appears out of the done state of a last slice
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_DONE && r_last))
        else $error("result without last slice");

endmodule
